>>> design/lrbd_pkg.sv
// ============================================================================
// lrbd_pkg
// Shared types and constants for the lidar ring bin despike unit.
// ============================================================================
package lrbd_pkg;

    localparam int DEGREES     = 360;
    localparam int DIST_W      = 16;
    localparam int AZ_W        = 9;
    localparam int INDEX_W     = 11;
    localparam int POINT_CNT_W = 4;
    localparam int WIN_TAPS    = 4;

    localparam logic [DIST_W-1:0] EMPTY_DIST = 16'hFF00;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              op;
        logic [AZ_W-1:0]   azimuth_deg;
        logic [DIST_W-1:0] distance;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  bin_distance;
        logic [INDEX_W-1:0] bin_index;
        logic               last;
    } t_out_item;

    // Position of the bin being read within its ring
    typedef enum logic [1:0] {
        ZONE_START,
        ZONE_END,
        ZONE_MID
    } t_zone;

    typedef struct packed {
        logic  load;
        t_zone zone;
    } t_desp_ctl;

    // r[0] and l[0] are the nearest neighbours
    typedef struct packed {
        logic [DIST_W-1:0]                c;
        logic [WIN_TAPS-1:0][DIST_W-1:0] r;
        logic [WIN_TAPS-1:0][DIST_W-1:0] l;
    } t_window;

endpackage

>>> design/lrbd_chan_if.sv
// ============================================================================
// lrbd_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ============================================================================
interface lrbd_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/lidar_ring_bin_despike_unit.sv
// ============================================================================
// lidar_ring_bin_despike_unit
// Bins lidar points per laser ring at minimum distance and reads the bins
// out through a despiking filter, emptying each bin as it is read.
// ============================================================================
//
//  Channel  Dir  Payload                                  Moves
//  i_pt     in   op, azimuth_deg, distance                one point or read request
//  o_bin    out  bin_distance, bin_index, last            one filtered bin
//
//  A point passes through division, bin store read, and compare and write back.
//  A read request passes through five reads of the bin and its four right
//  neighbours, capture, two filter stages and emit.
//  After reset a clearing pass writes every bin empty while i_pt is held
//  not ready.
//  A filtered bin waits in the output register; the emit cycle stalls until
//  that register is free, and i_pt stays not ready for as long as it stalls.
//
module lidar_ring_bin_despike_unit #(
    parameter int RINGS       = 16,
    parameter int DEG_PER_BIN = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrbd_chan_if.sink   i_pt,
    lrbd_chan_if.source o_bin
);
    import lrbd_pkg::*;

    localparam int BINS_PER_RING = DEGREES / DEG_PER_BIN;
    localparam int TOTAL_BINS    = RINGS * BINS_PER_RING;
    localparam int IDX_W         = $clog2(TOTAL_BINS);
    localparam int EXT_W         = $clog2(TOTAL_BINS + WIN_TAPS + 1);
    localparam int POS_W         = $clog2(BINS_PER_RING);
    localparam int RING_W        = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int DIV_SHIFT     = 20;
    localparam int DIV_MULT      = ((1 << DIV_SHIFT) + DEG_PER_BIN - 1) / DEG_PER_BIN;
    localparam int PROD_W        = AZ_W + DIV_SHIFT + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PT_DIV,
        S_PT_RD,
        S_PT_WR,
        S_RD_ADDR,
        S_RD_CAP,
        S_RD_SUM,
        S_RD_CMP,
        S_RD_EMIT
    } t_state;

    t_state r_state;

    logic [DIST_W-1:0] r_bin_mem [TOTAL_BINS];
    logic [DIST_W-1:0] r_rdata;

    logic [IDX_W-1:0]       r_clr_idx;
    logic [POINT_CNT_W-1:0] r_pt_cnt;
    logic [RING_W-1:0]      r_ring;
    logic [IDX_W-1:0]       r_ring_base;
    logic [IDX_W-1:0]       r_ptr;
    logic [POS_W-1:0]       r_rd_pos;
    logic [2:0]             r_k;
    logic                   r_cap_valid;
    logic [2:0]             r_cap_k;
    logic                   r_cap_oor;
    logic [AZ_W-1:0]        r_az;
    logic [DIST_W-1:0]      r_dist;
    logic [POS_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_addr;
    logic [DIST_W-1:0]      r_win  [WIN_TAPS+1];
    logic [DIST_W-1:0]      r_lwin [WIN_TAPS];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [AZ_W-1:0]   n_az;
    logic [PROD_W-1:0] n_prod;
    logic [9:0]        n_pos_full;
    logic [POS_W-1:0]  n_pos;
    logic [IDX_W-1:0]  pt_addr;
    logic [EXT_W-1:0]  rd_sum;
    logic              rd_oor;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [DIST_W-1:0] mem_wd;
    logic [IDX_W-1:0]  mem_ra;
    logic              emit_fire;
    logic              is_last;
    logic              in_fire;
    t_zone             zone;
    t_desp_ctl         desp_ctl;
    t_window           desp_win;
    logic [DIST_W-1:0] filt;

    assign i_pt.ready  = (r_state == S_IDLE);
    assign in_fire     = i_pt.valid && (r_state == S_IDLE);
    assign o_bin.valid = r_out_valid;
    assign o_bin.data  = r_out;

    // Azimuth wraps once at most, the field being 9 bits
    assign n_az = (i_pt.data.azimuth_deg >= AZ_W'(DEGREES))
                ? i_pt.data.azimuth_deg - AZ_W'(DEGREES)
                : i_pt.data.azimuth_deg;

    // Divide by DEG_PER_BIN through a rounded-up reciprocal
    assign n_prod     = PROD_W'(r_az) * PROD_W'(DIV_MULT);
    assign n_pos_full = n_prod[DIV_SHIFT +: 10];
    assign n_pos      = (n_pos_full > 10'(BINS_PER_RING - 1))
                      ? POS_W'(BINS_PER_RING - 1) : POS_W'(n_pos_full);

    assign pt_addr = r_ring_base + IDX_W'(r_pos);

    assign rd_sum = EXT_W'(r_ptr) + EXT_W'(r_k);
    assign rd_oor = (rd_sum >= EXT_W'(TOTAL_BINS));

    assign is_last   = (r_ptr == IDX_W'(TOTAL_BINS - 1));
    assign emit_fire = (r_state == S_RD_EMIT) && (!r_out_valid || o_bin.ready);

    always_comb begin
        if (r_rd_pos < POS_W'(WIN_TAPS)) begin
            zone = ZONE_START;
        end else if (r_rd_pos >= POS_W'(BINS_PER_RING - WIN_TAPS)) begin
            zone = ZONE_END;
        end else begin
            zone = ZONE_MID;
        end
    end

    always_comb begin
        desp_ctl.load = (r_state == S_RD_SUM);
        desp_ctl.zone = zone;
        desp_win.c    = r_win[0];
        for (int i = 0; i < WIN_TAPS; i++) begin
            desp_win.r[i] = r_win[i+1];
            desp_win.l[i] = r_lwin[i];
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr;
        mem_wd = EMPTY_DIST;
        mem_ra = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_idx;
            end
            S_PT_RD: begin
                mem_ra = pt_addr;
            end
            S_PT_WR: begin
                mem_we = (r_dist < r_rdata);
                mem_wa = r_addr;
                mem_wd = r_dist;
            end
            S_RD_ADDR: begin
                mem_ra = rd_oor ? '0 : rd_sum[IDX_W-1:0];
            end
            S_RD_EMIT: begin
                mem_we = emit_fire;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bin_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_bin_mem[mem_ra];
    end

    lrbd_despike u_despike (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (desp_ctl),
        .i_win   (desp_win),
        .o_filt  (filt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_pt_cnt    <= '0;
            r_ring      <= '0;
            r_ring_base <= '0;
            r_ptr       <= '0;
            r_rd_pos    <= '0;
            r_k         <= '0;
            r_cap_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WIN_TAPS; i++) begin
                r_lwin[i] <= '0;
            end
        end else begin
            r_cap_valid <= (r_state == S_RD_ADDR);
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_bin.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(TOTAL_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_pt.data.op == OP_ADD) begin
                            r_az    <= n_az;
                            r_dist  <= i_pt.data.distance;
                            r_state <= S_PT_DIV;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_RD_ADDR;
                        end
                    end
                end
                S_PT_DIV: begin
                    r_pos   <= n_pos;
                    r_state <= S_PT_RD;
                end
                S_PT_RD: begin
                    r_addr  <= pt_addr;
                    r_state <= S_PT_WR;
                end
                S_PT_WR: begin
                    // advance the ring; it restarts after the last ring or when the point counter wraps
                    r_pt_cnt <= r_pt_cnt + 1'b1;
                    if (r_pt_cnt == POINT_CNT_W'(15) || r_ring == RING_W'(RINGS - 1)) begin
                        r_ring      <= '0;
                        r_ring_base <= '0;
                    end else begin
                        r_ring      <= r_ring + 1'b1;
                        r_ring_base <= r_ring_base + IDX_W'(BINS_PER_RING);
                    end
                    r_state <= S_IDLE;
                end
                S_RD_ADDR: begin
                    r_cap_k     <= r_k;
                    r_cap_oor   <= rd_oor;
                    if (r_k == 3'(WIN_TAPS)) begin
                        r_k     <= '0;
                        r_state <= S_RD_CAP;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_RD_CAP: begin
                    r_state <= S_RD_SUM;
                end
                S_RD_SUM: begin
                    r_state <= S_RD_CMP;
                end
                S_RD_CMP: begin
                    r_state <= S_RD_EMIT;
                end
                S_RD_EMIT: begin
                    if (emit_fire) begin
                        r_out.bin_distance <= filt;
                        r_out.bin_index    <= INDEX_W'(r_ptr);
                        r_out.last         <= is_last;
                        for (int i = 1; i < WIN_TAPS; i++) begin
                            r_lwin[i] <= r_lwin[i-1];
                        end
                        r_lwin[0] <= filt;
                        if (is_last) begin
                            r_ptr       <= '0;
                            r_rd_pos    <= '0;
                            r_pt_cnt    <= '0;
                            r_ring      <= '0;
                            r_ring_base <= '0;
                        end else begin
                            r_ptr <= r_ptr + 1'b1;
                            if (r_rd_pos == POS_W'(BINS_PER_RING - 1)) begin
                                r_rd_pos <= '0;
                            end else begin
                                r_rd_pos <= r_rd_pos + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // bins past the end of the store read as empty
            if (r_cap_valid) begin
                r_win[r_cap_k] <= r_cap_oor ? EMPTY_DIST : r_rdata;
            end
        end
    end

endmodule

>>> design/lrbd_despike.sv
// ============================================================================
// lrbd_despike
// Two-stage spike test of one bin against its right, left or both neighbours.
// ============================================================================
module lrbd_despike (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrbd_pkg::t_desp_ctl           i_ctl,
    input  lrbd_pkg::t_window             i_win,
    output logic [lrbd_pkg::DIST_W-1:0]   o_filt
);
    import lrbd_pkg::*;

    function automatic logic [DIST_W-1:0] adiff(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
        adiff = (a > b) ? a - b : b - a;
    endfunction

    logic              r_load_d;
    t_zone             r_zone;
    logic [DIST_W-1:0] r_c;
    logic [DIST_W-1:0] r_r1;
    logic [DIST_W-1:0] r_l1;
    logic [DIST_W-1:0] r_avg;
    logic [DIST_W-1:0] r_d_cr;
    logic [DIST_W-1:0] r_d_cl;
    logic [DIST_W+1:0] r_lsum;
    logic [DIST_W+1:0] r_rsum;

    logic [DIST_W:0]   n_lr_sum;
    logic [DIST_W+1:0] n_lsum;
    logic [DIST_W+1:0] n_rsum;
    logic [DIST_W+1:0] cr3;
    logic [DIST_W+1:0] cl3;
    logic [DIST_W:0]   cen;
    logic [DIST_W+2:0] cen3;
    logic [DIST_W-1:0] n_filt;

    assign n_lr_sum = {1'b0, i_win.l[0]} + {1'b0, i_win.r[0]};
    assign n_lsum = {2'b00, adiff(i_win.l[3], i_win.l[2])}
                  + {2'b00, adiff(i_win.l[2], i_win.l[1])}
                  + {2'b00, adiff(i_win.l[1], i_win.l[0])};
    assign n_rsum = {2'b00, adiff(i_win.r[3], i_win.r[2])}
                  + {2'b00, adiff(i_win.r[2], i_win.r[1])}
                  + {2'b00, adiff(i_win.r[1], i_win.r[0])};

    // Times three as x + 2x
    assign cr3  = {2'b00, r_d_cr} + {1'b0, r_d_cr, 1'b0};
    assign cl3  = {2'b00, r_d_cl} + {1'b0, r_d_cl, 1'b0};
    assign cen  = {1'b0, r_d_cr} + {1'b0, r_d_cl};
    assign cen3 = {2'b00, cen} + {1'b0, cen, 1'b0};

    always_comb begin
        n_filt = r_c;
        case (r_zone)
            ZONE_START: begin
                if (cr3 > r_rsum) begin
                    n_filt = r_r1;
                end
            end
            ZONE_END: begin
                if (cl3 > r_lsum) begin
                    n_filt = r_l1;
                end
            end
            ZONE_MID: begin
                if (cen3 > {r_lsum, 1'b0} && cen3 > {r_rsum, 1'b0}) begin
                    n_filt = r_avg;
                end
            end
            default: n_filt = r_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_d <= 1'b0;
        end else begin
            r_load_d <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_zone <= i_ctl.zone;
            r_c    <= i_win.c;
            r_r1   <= i_win.r[0];
            r_l1   <= i_win.l[0];
            r_avg  <= n_lr_sum[DIST_W:1];
            r_d_cr <= adiff(i_win.c, i_win.r[0]);
            r_d_cl <= adiff(i_win.c, i_win.l[0]);
            r_lsum <= n_lsum;
            r_rsum <= n_rsum;
        end
        if (r_load_d) begin
            o_filt <= n_filt;
        end
    end

endmodule
